FILE: hw/rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_WIDTH  = 16;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int NW = PW + FRAC_BITS;
    localparam int CW = 3 * DATA_WIDTH + FRAC_BITS;

    localparam int PREP_STAGES = 3;
    localparam int NUM_STAGES  = PREP_STAGES + DATA_WIDTH + 1;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(66);

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_CDIV  = 3'd3,
        CMD_CONJ  = 3'd4,
        CMD_MODSQ = 3'd5,
        CMD_CMP   = 3'd6,
        CMD_SDIV  = 3'd7
    } cau_cmd_t;

    typedef struct packed {
        logic [NW-1:0]         rem_re;
        logic [NW-1:0]         rem_im;
        logic [CW-1:0]         dvs;
        logic [DATA_WIDTH-1:0] q_re;
        logic [DATA_WIDTH-1:0] q_im;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic                  is_div;
        logic                  err;
        logic                  equal;
        logic [DATA_WIDTH-1:0] pass_re;
        logic [DATA_WIDTH-1:0] pass_im;
    } cau_lane_t;

    function automatic logic [DATA_WIDTH-1:0] cau_sat(input logic signed [SW-1:0] v);
        logic [DATA_WIDTH-1:0] r;
        if (v[SW-1:DATA_WIDTH-1] == {(SW-DATA_WIDTH+1){v[SW-1]}})
        begin
            r = v[DATA_WIDTH-1:0];
        end
        else
        begin
            r = v[SW-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cau_div_cell.sv
`default_nettype none

module cau_div_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  cau_pkg::cau_lane_t     in_lane,
    output logic                   out_vld,
    output cau_pkg::cau_lane_t     out_lane
);
    import cau_pkg::*;

    logic       vld_reg;
    cau_lane_t  lane_reg;
    cau_lane_t  lane_next;
    logic       ge_re;
    logic       ge_im;
    logic [CW-1:0] rem_re_w;
    logic [CW-1:0] rem_im_w;

    always_comb
    begin
        lane_next = in_lane;
        rem_re_w  = CW'(in_lane.rem_re);
        rem_im_w  = CW'(in_lane.rem_im);
        ge_re     = rem_re_w >= in_lane.dvs;
        ge_im     = rem_im_w >= in_lane.dvs;
        if (ge_re)
        begin
            lane_next.rem_re = NW'(rem_re_w - in_lane.dvs);
        end
        if (ge_im)
        begin
            lane_next.rem_im = NW'(rem_im_w - in_lane.dvs);
        end
        lane_next.q_re = {in_lane.q_re[DATA_WIDTH-2:0], ge_re};
        lane_next.q_im = {in_lane.q_im[DATA_WIDTH-2:0], ge_im};
        lane_next.dvs  = in_lane.dvs >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_lane = lane_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/cau_prep.sv
`default_nettype none

module cau_prep (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [cau_pkg::PREP_STAGES-1:0]        en,
    input  wire logic                                   in_vld,
    input  wire logic [2:0]                             command,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im,
    input  wire logic [cau_pkg::TOL_WIDTH-1:0]          tol,
    output logic [cau_pkg::PREP_STAGES-1:0]             vld,
    output cau_pkg::cau_lane_t                          lane
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;

    // stage A: products, add/sub/conj, compare
    cau_cmd_t                cmd;
    logic signed [DW-1:0]    x0, y0, x1, y1;
    logic signed [PW-1:0]    prod_next [6];
    logic [DW-1:0]           pass_re_next, pass_im_next;
    logic                    eq_next;
    logic signed [SW-1:0]    d_re, d_im;
    logic [SW-1:0]           ad_re, ad_im;

    logic                    a_vld_reg;
    cau_cmd_t                a_cmd_reg;
    logic signed [DW-1:0]    a_re_reg, a_im_reg, b_re_reg;
    logic signed [PW-1:0]    prod_reg [6];
    logic [DW-1:0]           a_pass_re_reg, a_pass_im_reg;
    logic                    a_eq_reg, a_bz_reg, a_biz_reg;

    always_comb
    begin
        cmd = cau_cmd_t'(command);
        x0  = a_re;
        x1  = a_im;
        y0  = (cmd == CMD_MODSQ) ? a_re : b_re;
        y1  = (cmd == CMD_MODSQ) ? a_im : b_im;
        prod_next[0] = x0 * y0;
        prod_next[1] = x1 * y1;
        prod_next[2] = a_re * b_im;
        prod_next[3] = a_im * b_re;
        prod_next[4] = b_re * b_re;
        prod_next[5] = b_im * b_im;

        d_re  = SW'(b_re) - SW'(a_re);
        d_im  = SW'(b_im) - SW'(a_im);
        ad_re = d_re[SW-1] ? $unsigned(-d_re) : $unsigned(d_re);
        ad_im = d_im[SW-1] ? $unsigned(-d_im) : $unsigned(d_im);

        pass_re_next = '0;
        pass_im_next = '0;
        eq_next      = 1'b0;
        unique case (cmd)
            CMD_ADD:
            begin
                pass_re_next = cau_sat(SW'(a_re) + SW'(b_re));
                pass_im_next = cau_sat(SW'(a_im) + SW'(b_im));
            end
            CMD_SUB:
            begin
                pass_re_next = cau_sat(SW'(a_re) - SW'(b_re));
                pass_im_next = cau_sat(SW'(a_im) - SW'(b_im));
            end
            CMD_CONJ:
            begin
                pass_re_next = a_re;
                pass_im_next = cau_sat(-SW'(a_im));
            end
            CMD_CMP:
            begin
                eq_next = (ad_re <= SW'(tol)) && (ad_im <= SW'(tol));
            end
            default:
            begin
                pass_re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en[0])
        begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_cmd_reg     <= cmd;
            a_re_reg      <= a_re;
            a_im_reg      <= a_im;
            b_re_reg      <= b_re;
            prod_reg      <= prod_next;
            a_pass_re_reg <= pass_re_next;
            a_pass_im_reg <= pass_im_next;
            a_eq_reg      <= eq_next;
            a_bz_reg      <= (b_re == '0);
            a_biz_reg     <= (b_im == '0);
        end
    end

    // stage B: sums, rounding, divide operands
    logic signed [SW-1:0] s_mre, s_mim, s_add, s_nim;
    logic [PW-1:0]        den;
    logic [PW-1:0]        m_add, m_nim;
    logic signed [SW-1:0] ea_re, ea_im, eb_re;
    logic [PW-1:0]        abs_are, abs_aim, abs_bre;
    logic [NW-1:0]        nre_next, nim_next;
    logic [PW-1:0]        den_next;
    logic                 neg_re_next, neg_im_next, div_next, err_next;
    logic [DW-1:0]        b_pass_re_next, b_pass_im_next;

    logic                 b_vld_reg;
    logic [NW-1:0]        b_nre_reg, b_nim_reg;
    logic [PW-1:0]        b_den_reg;
    logic                 b_neg_re_reg, b_neg_im_reg, b_div_reg, b_err_reg, b_eq_reg;
    logic [DW-1:0]        b_pass_re_reg, b_pass_im_reg;

    always_comb
    begin
        s_mre = SW'(prod_reg[0]) - SW'(prod_reg[1]);
        s_mim = SW'(prod_reg[2]) + SW'(prod_reg[3]);
        s_add = SW'(prod_reg[0]) + SW'(prod_reg[1]);
        s_nim = SW'(prod_reg[3]) - SW'(prod_reg[2]);
        den   = $unsigned(prod_reg[4]) + $unsigned(prod_reg[5]);
        m_add = s_add[SW-1] ? PW'(-s_add) : PW'(s_add);
        m_nim = s_nim[SW-1] ? PW'(-s_nim) : PW'(s_nim);
        ea_re = SW'(a_re_reg);
        ea_im = SW'(a_im_reg);
        eb_re = SW'(b_re_reg);
        abs_are = ea_re[SW-1] ? PW'(-ea_re) : PW'(ea_re);
        abs_aim = ea_im[SW-1] ? PW'(-ea_im) : PW'(ea_im);
        abs_bre = eb_re[SW-1] ? PW'(-eb_re) : PW'(eb_re);

        nre_next       = '0;
        nim_next       = '0;
        den_next       = '0;
        neg_re_next    = 1'b0;
        neg_im_next    = 1'b0;
        div_next       = 1'b0;
        err_next       = 1'b0;
        b_pass_re_next = a_pass_re_reg;
        b_pass_im_next = a_pass_im_reg;
        unique case (a_cmd_reg)
            CMD_MUL:
            begin
                b_pass_re_next = cau_sat(s_mre >>> FRAC_BITS);
                b_pass_im_next = cau_sat(s_mim >>> FRAC_BITS);
            end
            CMD_MODSQ:
            begin
                b_pass_re_next = cau_sat(s_add >>> FRAC_BITS);
                b_pass_im_next = '0;
            end
            CMD_CDIV:
            begin
                err_next    = a_bz_reg && a_biz_reg;
                div_next    = !err_next;
                nre_next    = NW'(m_add) << FRAC_BITS;
                nim_next    = NW'(m_nim) << FRAC_BITS;
                den_next    = den;
                neg_re_next = s_add[SW-1];
                neg_im_next = s_nim[SW-1];
            end
            CMD_SDIV:
            begin
                err_next    = a_bz_reg;
                div_next    = !err_next;
                nre_next    = NW'(abs_are) << FRAC_BITS;
                nim_next    = NW'(abs_aim) << FRAC_BITS;
                den_next    = abs_bre;
                neg_re_next = a_re_reg[DW-1] ^ b_re_reg[DW-1];
                neg_im_next = a_im_reg[DW-1] ^ b_re_reg[DW-1];
            end
            default:
            begin
                div_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en[1])
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_nre_reg     <= nre_next;
            b_nim_reg     <= nim_next;
            b_den_reg     <= den_next;
            b_neg_re_reg  <= neg_re_next;
            b_neg_im_reg  <= neg_im_next;
            b_div_reg     <= div_next;
            b_err_reg     <= err_next;
            b_eq_reg      <= a_eq_reg;
            b_pass_re_reg <= b_pass_re_next;
            b_pass_im_reg <= b_pass_im_next;
        end
    end

    // stage C: overflow check, divisor alignment
    cau_lane_t     c_lane_next;
    logic [CW-1:0] dlim;
    logic          c_vld_reg;
    cau_lane_t     c_lane_reg;

    always_comb
    begin
        dlim = CW'(b_den_reg) << DW;
        c_lane_next.rem_re  = b_nre_reg;
        c_lane_next.rem_im  = b_nim_reg;
        c_lane_next.dvs     = CW'(b_den_reg) << (DW - 1);
        c_lane_next.q_re    = '0;
        c_lane_next.q_im    = '0;
        c_lane_next.neg_re  = b_neg_re_reg;
        c_lane_next.neg_im  = b_neg_im_reg;
        c_lane_next.ovf_re  = CW'(b_nre_reg) >= dlim;
        c_lane_next.ovf_im  = CW'(b_nim_reg) >= dlim;
        c_lane_next.is_div  = b_div_reg;
        c_lane_next.err     = b_err_reg;
        c_lane_next.equal   = b_eq_reg;
        c_lane_next.pass_re = b_pass_re_reg;
        c_lane_next.pass_im = b_pass_im_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en[2])
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_lane_reg <= c_lane_next;
        end
    end

    assign vld  = {c_vld_reg, b_vld_reg, a_vld_reg};
    assign lane = c_lane_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit_core.sv
`default_nettype none

// Complex arithmetic unit on signed Q16.16 operands.
// Input channel: in_valid/in_stall with command, a_re, a_im, b_re, b_im.
// Output channel: out_valid/out_stall with res_re, res_im, equal, div_error.
// A transaction moves on either channel at a clock edge with valid high and
// stall low. Configuration: cfg_valid/cfg_ready/cfg_data writes the compare
// tolerance; cfg_ready is always high. Write it only while the block is idle.
// Path: three setup stages, one divider cell per quotient bit and one output
// register; every command takes the same path. Throughput: one transaction
// per cycle while out_stall stays low.
// The pipeline collapses bubbles: when the receiver stalls, the result holds
// and upstream stages keep filling until every stage is occupied, then
// in_stall rises. Reset clears all valid bits and sets the tolerance to 66.

module complex_arithmetic_unit_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [2:0]                             command,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0]  b_im,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]       res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]       res_im,
    output logic                                        equal,
    output logic                                        div_error,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [cau_pkg::TOL_WIDTH-1:0]          cfg_data
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int LAST = NUM_STAGES - 1;

    logic [TOL_WIDTH-1:0]  tol_reg;
    logic [NUM_STAGES-1:0] vld;
    logic [NUM_STAGES-1:0] adv;
    cau_lane_t             chain [DW+1];
    logic [DW:1]           chain_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    assign adv[LAST] = !vld[LAST] || !out_stall;
    for (genvar k = 0; k < LAST; k++)
    begin : g_adv
        assign adv[k] = !vld[k] || adv[k+1];
    end

    assign in_stall = !adv[0];

    cau_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv[PREP_STAGES-1:0]),
        .in_vld  (in_valid),
        .command (command),
        .a_re    (a_re),
        .a_im    (a_im),
        .b_re    (b_re),
        .b_im    (b_im),
        .tol     (tol_reg),
        .vld     (vld[PREP_STAGES-1:0]),
        .lane    (chain[0])
    );

    for (genvar k = 0; k < DW; k++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv[PREP_STAGES+k]),
            .in_vld   (vld[PREP_STAGES+k-1]),
            .in_lane  (chain[k]),
            .out_vld  (chain_vld[k+1]),
            .out_lane (chain[k+1])
        );
        assign vld[PREP_STAGES+k] = chain_vld[k+1];
    end

    function automatic logic [DW-1:0] fin(
        input logic          is_div,
        input logic          ovf,
        input logic          neg,
        input logic [DW-1:0] q,
        input logic [DW-1:0] pass
    );
        logic [DW-1:0] r;
        if (!is_div)
        begin
            r = pass;
        end
        else if (ovf)
        begin
            r = neg ? SAT_MIN : SAT_MAX;
        end
        else if (!neg)
        begin
            r = q[DW-1] ? SAT_MAX : q;
        end
        else
        begin
            r = (q > SAT_MIN) ? SAT_MIN : (DW'(0) - q);
        end
        return r;
    endfunction

    cau_lane_t     tail;
    logic          out_vld_reg;
    logic [DW-1:0] res_re_reg, res_im_reg;
    logic          equal_reg, err_reg;

    assign tail = chain[DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv[LAST])
        begin
            out_vld_reg <= vld[LAST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            res_re_reg <= fin(tail.is_div, tail.ovf_re, tail.neg_re, tail.q_re, tail.pass_re);
            res_im_reg <= fin(tail.is_div, tail.ovf_im, tail.neg_im, tail.q_im, tail.pass_im);
            equal_reg  <= tail.equal;
            err_reg    <= tail.err;
        end
    end

    assign vld[LAST] = out_vld_reg;
    assign out_valid = out_vld_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign equal     = equal_reg;
    assign div_error = err_reg;

endmodule

`default_nettype wire

FILE: verif/cau_checker.sv
module cau_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_stall,
    input  wire logic [2:0]                            command,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_stall,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
    input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
    input  wire logic                                  equal,
    input  wire logic                                  div_error,
    input  wire logic                                  cfg_valid,
    input  wire logic                                  cfg_ready,
    input  wire logic [cau_pkg::TOL_WIDTH-1:0]         cfg_data,
    output int                                         errors,
    output int                                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic                         eq;
        logic                         err;
    } cau_result_t;

    cau_result_t result_q[$];
    logic [TOL_WIDTH-1:0] tolerance;

    function automatic logic signed [DATA_WIDTH-1:0] clamp(input logic signed [255:0] v);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (DATA_WIDTH-1)) - 256'sd1;
        lo = -hi - 256'sd1;
        if (v > hi) return hi[DATA_WIDTH-1:0];
        if (v < lo) return lo[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

    // signed division truncated toward zero
    function automatic logic signed [255:0] tdiv(input logic signed [255:0] n,
                                                 input logic signed [255:0] d);
        logic [255:0] q;
        q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic cau_result_t compute(input logic [2:0] cmd,
                                            input logic signed [255:0] ar,
                                            input logic signed [255:0] ai,
                                            input logic signed [255:0] br,
                                            input logic signed [255:0] bi,
                                            input logic [TOL_WIDTH-1:0] tol);
        cau_result_t r;
        logic signed [255:0] re;
        logic signed [255:0] im;
        logic signed [255:0] den;
        logic signed [255:0] dre;
        logic signed [255:0] dim;
        re = 0;
        im = 0;
        r.eq = 1'b0;
        r.err = 1'b0;
        case (cau_cmd_t'(cmd))
            CMD_ADD: begin re = ar + br; im = ai + bi; end
            CMD_SUB: begin re = ar - br; im = ai - bi; end
            CMD_MUL:
            begin
                re = (ar * br - ai * bi) >>> FRAC_BITS;
                im = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            CMD_CDIV:
            begin
                if (br == 0 && bi == 0) r.err = 1'b1;
                else
                begin
                    den = br * br + bi * bi;
                    re = tdiv((ar * br + ai * bi) <<< FRAC_BITS, den);
                    im = tdiv((ai * br - ar * bi) <<< FRAC_BITS, den);
                end
            end
            CMD_CONJ: begin re = ar; im = -ai; end
            CMD_MODSQ: re = (ar * ar + ai * ai) >>> FRAC_BITS;
            CMD_CMP:
            begin
                dre = br - ar;
                dim = bi - ai;
                if (dre < 0) dre = -dre;
                if (dim < 0) dim = -dim;
                r.eq = (dre <= $signed({240'd0, tol})) && (dim <= $signed({240'd0, tol}));
            end
            default:
            begin
                if (br == 0) r.err = 1'b1;
                else
                begin
                    re = tdiv(ar <<< FRAC_BITS, br);
                    im = tdiv(ai <<< FRAC_BITS, br);
                end
            end
        endcase
        r.re = clamp(re);
        r.im = clamp(im);
        return r;
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cau_result_t want;
        if (!rst_n)
        begin
            tolerance <= TOL_RESET;
            errors    <= 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) tolerance <= cfg_data;
            if (in_valid && !in_stall)
                result_q.push_back(compute(command, a_re, a_im, b_re, b_im, tolerance));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction re=%h im=%h eq=%b err=%b",
                             $time, res_re, res_im, equal, div_error);
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want !== {res_re, res_im, equal, div_error})
                    begin
                        $display("%0t: mismatch expected re=%h im=%h eq=%b err=%b",
                                 $time, want.re, want.im, want.eq, want.err);
                        $display("%0t:          actual   re=%h im=%h eq=%b err=%b",
                                 $time, res_re, res_im, equal, div_error);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] command;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
    logic out_valid;
    logic out_stall;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic equal;
    logic div_error;
    logic cfg_valid;
    logic cfg_ready;
    logic [TOL_WIDTH-1:0] cfg_data;
    int errors;
    int pending;
    int idle_cycles;
    bit calm;

    complex_arithmetic_unit_core u_dut (.*);

    cau_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);

    function automatic logic [DATA_WIDTH-1:0] rand_operand();
        case ($urandom_range(9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
            4: return $signed(16'($urandom)) ;
            5: return $signed(24'($urandom));
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input cau_cmd_t cmd, input logic [31:0] ar, input logic [31:0] ai,
                        input logic [31:0] br, input logic [31:0] bi);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_WIDTH-1:0] tol);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        logic [31:0] ar;
        logic [31:0] ai;
        for (int i = 0; i < count; i++)
        begin
            ar = rand_operand();
            ai = rand_operand();
            if ($urandom_range(3) == 0)
                send(CMD_CMP, ar, ai, $signed(ar) + $signed(17'($urandom)) / 2,
                     $signed(ai) + $signed(17'($urandom)) / 2);
            else
                send(cau_cmd_t'($urandom_range(7)), ar, ai, rand_operand(), rand_operand());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = '0;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int c = 0; c < 8; c++)
            send(cau_cmd_t'(c), SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX);
        send(CMD_CDIV, 32'h0003_0000, 32'h0001_0000, '0, '0);
        send(CMD_SDIV, 32'h0003_0000, 32'h0001_0000, '0, 32'h0001_0000);
        send(CMD_SDIV, SAT_MIN, SAT_MAX, 32'hffff_ffff, '0);
        send(CMD_CDIV, SAT_MAX, SAT_MIN, 32'h0000_0001, '0);
        send(CMD_CONJ, '0, SAT_MIN, '0, '0);
        send(CMD_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
        send(CMD_MODSQ, SAT_MIN, SAT_MIN, '0, '0);
        send(CMD_MUL, 32'hffff_ffff, '0, 32'h0000_0001, '0);
        send(CMD_CMP, 32'h0001_0000, '0, 32'h0001_0042, 32'hffff_ffbe);
        send(CMD_CMP, 32'h0001_0000, '0, 32'h0001_0043, '0);
        send(CMD_CMP, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX);
        random_phase(400);
        set_tolerance('0);
        send(CMD_CMP, 32'h0000_1234, 32'h5, 32'h0000_1234, 32'h5);
        send(CMD_CMP, 32'h0000_1234, 32'h5, 32'h0000_1235, 32'h5);
        random_phase(300);
        set_tolerance(16'hffff);
        send(CMD_CMP, '0, '0, 32'h0000_ffff, 32'hffff_0001);
        send(CMD_CMP, '0, '0, 32'h0001_0000, '0);
        calm = 1'b1;
        random_phase(300);
        calm = 1'b0;
        set_tolerance(TOL_WIDTH'($urandom));
        random_phase(500);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
